// ===== hdl/gwc_pkg.sv =====
// gwc_pkg: shared types, constants and helpers of the window coefficient generator
// no dependencies
package gwc_pkg;

    typedef enum logic [1:0] {
        CMD_RECT   = 2'd0,
        CMD_GAUSS  = 2'd1,
        CMD_SMOOTH = 2'd2,
        CMD_DELTA  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [14:0] scale;
        logic [11:0] scale_mult;
    } req_t;

    typedef struct packed {
        logic signed [15:0] coefficient;
        logic [5:0]         tap_index;
        logic               last;
        logic               truncated;
        logic               empty_res;
    } tap_t;

    localparam int DIV_W  = 56;
    localparam int DEN_W  = 32;
    localparam int R_W    = 19;
    localparam int E_W    = 24;
    localparam int SUM_W  = 32;

    localparam logic [18:0] K_WIDTH  = 19'd298338;
    localparam logic [23:0] EXP_MAX  = 24'hFFFFFF;
    localparam logic [55:0] R_LIMIT  = 56'(5) << 16;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic           start;
        logic [R_W-1:0] r;
    } exp_req_t;

    typedef struct packed {
        logic           done;
        logic [E_W-1:0] e;
    } exp_rsp_t;

    function automatic logic signed [15:0] sat16(input logic [56:0] mag, input logic neg);
        logic signed [15:0] res;
        if (neg) begin
            if (mag > 57'd32768) begin
                res = 16'sh8000;
            end else begin
                res = 16'(57'd0 - mag);
            end
        end else begin
            if (mag > 57'd32767) begin
                res = 16'sh7FFF;
            end else begin
                res = mag[15:0];
            end
        end
        return res;
    endfunction

endpackage

// ===== hdl/gaussian_window_coefficient_generator_unit.sv =====
// one request at a time; req_ready is high only between windows
// kinds 1..3: each Gaussian value is filled with at most one divide and one exp, and each tap
// out takes at most one divide (two for delta); the shared restoring divider sets their rate
// rect: one divide, then one tap per cycle while tap_ready holds; a zero-width rect gives one marker
// the output register lets a tap wait on tap_ready
// rst_n clears control and sums asynchronously; the tap memories are not cleared
module gaussian_window_coefficient_generator_unit #(
    parameter int MAX_TAPS = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  gwc_pkg::req_t req,
    output logic          tap_valid,
    input  logic          tap_ready,
    output gwc_pkg::tap_t tap
);
    import gwc_pkg::*;

    localparam int AW = $clog2(MAX_TAPS);
    localparam int CW = $clog2(MAX_TAPS + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_MULQ, S_CNT, S_CLAMP, S_RECTDIV, S_EMPTY, S_GSTART, S_GDIV,
        S_GEXP, S_GWRITE, S_PREP, S_RD, S_RDW, S_DIVA, S_DIVB, S_PUSH
    } st_t;

    st_t                state_reg;
    cmd_t               cmd_reg;
    logic [14:0]        scale_reg;
    logic [11:0]        mult_reg;
    logic [26:0]        q1_reg;
    logic [45:0]        prod_reg;
    logic [CW-1:0]      n_reg;
    logic               trunc_reg;
    logic [CW-1:0]      idx_reg;
    logic               sel_reg;
    logic [E_W-1:0]     e_reg;
    logic [SUM_W-1:0]   fs_reg;
    logic [SUM_W-1:0]   ss_reg;
    logic signed [32:0] dsum_reg;
    logic [E_W-1:0]     t_reg;
    logic [DIV_W-1:0]   a_reg;
    logic               neg_reg;
    logic signed [15:0] coef_reg;
    div_req_t           div_req_reg;
    exp_req_t           exp_req_reg;
    logic               tap_valid_reg;
    tap_t               tap_reg;

    div_rsp_t           div_rsp;
    exp_rsp_t           exp_rsp;
    logic [E_W-1:0]     rd_first;
    logic [E_W-1:0]     rd_second;

    logic [22:0]        q0;
    logic [26:0]        qmax;
    logic [26:0]        qsel;
    logic [14:0]        n_raw;
    logic signed [24:0] dval;
    logic [24:0]        dmag;
    logic [31:0]        smag;
    logic signed [56:0] diff;
    logic [56:0]        diff_mag;
    logic               slot_free;
    logic               is_last;

    assign q0        = {scale_reg, 8'b0};
    assign qmax      = (q1_reg > 27'(q0)) ? q1_reg : 27'(q0);
    assign qsel      = sel_reg ? q1_reg : 27'(q0);
    assign n_raw     = (cmd_reg == CMD_RECT) ? 15'(scale_reg[14:8])
                                             : 15'(prod_reg[45:32]) + 15'd1;
    assign dval      = $signed({1'b0, rd_first}) - $signed({1'b0, rd_second});
    assign dmag      = dval[24] ? 25'(-dval) : 25'(dval);
    assign smag      = dsum_reg[32] ? 32'(-dsum_reg) : 32'(dsum_reg);
    assign diff      = $signed({1'b0, a_reg}) - $signed({1'b0, div_rsp.quotient});
    assign diff_mag  = diff[56] ? 57'(-diff) : 57'(diff);
    assign slot_free = !tap_valid_reg || tap_ready;
    assign is_last   = (idx_reg + 1'b1) == n_reg;

    gwc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req_reg),
        .rsp   (div_rsp)
    );

    gwc_exp u_exp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (exp_req_reg),
        .rsp   (exp_rsp)
    );

    gwc_store #(
        .MAX_TAPS (MAX_TAPS)
    ) u_store (
        .clk       (clk),
        .we        (state_reg == S_GWRITE),
        .sel       (sel_reg),
        .wr_addr   (idx_reg[AW-1:0]),
        .wr_data   (e_reg),
        .rd_addr   (idx_reg[AW-1:0]),
        .rd_first  (rd_first),
        .rd_second (rd_second)
    );

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            cmd_reg       <= CMD_RECT;
            scale_reg     <= '0;
            mult_reg      <= '0;
            q1_reg        <= '0;
            prod_reg      <= '0;
            n_reg         <= '0;
            trunc_reg     <= 1'b0;
            idx_reg       <= '0;
            sel_reg       <= 1'b0;
            e_reg         <= '0;
            fs_reg        <= '0;
            ss_reg        <= '0;
            dsum_reg      <= '0;
            t_reg         <= '0;
            a_reg         <= '0;
            neg_reg       <= 1'b0;
            coef_reg      <= '0;
            div_req_reg   <= '0;
            exp_req_reg   <= '0;
            tap_valid_reg <= 1'b0;
            tap_reg       <= '0;
        end else begin
            div_req_reg.start <= 1'b0;
            exp_req_reg.start <= 1'b0;
            if (tap_ready) begin
                tap_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (req_valid) begin
                        cmd_reg   <= cmd_t'(req.cmd);
                        scale_reg <= req.scale;
                        mult_reg  <= req.scale_mult;
                        state_reg <= S_MULQ;
                    end
                end
                S_MULQ: begin
                    q1_reg    <= scale_reg * mult_reg;
                    state_reg <= S_CNT;
                end
                S_CNT: begin
                    prod_reg  <= K_WIDTH * qmax;
                    state_reg <= S_CLAMP;
                end
                S_CLAMP: begin
                    idx_reg <= '0;
                    sel_reg <= 1'b0;
                    fs_reg  <= '0;
                    ss_reg  <= '0;
                    if (n_raw > 15'(MAX_TAPS)) begin
                        n_reg     <= CW'(MAX_TAPS);
                        trunc_reg <= 1'b1;
                    end else begin
                        n_reg     <= CW'(n_raw);
                        trunc_reg <= 1'b0;
                    end
                    if (cmd_reg == CMD_RECT) begin
                        if (n_raw == '0) begin
                            state_reg <= S_EMPTY;
                        end else begin
                            div_req_reg.start    <= 1'b1;
                            div_req_reg.dividend <= (DIV_W'(1) << 23) + DIV_W'(scale_reg >> 1);
                            div_req_reg.divisor  <= DEN_W'(scale_reg);
                            state_reg            <= S_RECTDIV;
                        end
                    end else begin
                        state_reg <= S_GSTART;
                    end
                end
                S_EMPTY: begin
                    if (slot_free) begin
                        tap_valid_reg <= 1'b1;
                        tap_reg       <= '{coefficient: '0, tap_index: '0, last: 1'b1,
                                           truncated: 1'b0, empty_res: 1'b1};
                        state_reg     <= S_IDLE;
                    end
                end
                S_RECTDIV: begin
                    if (div_rsp.done) begin
                        coef_reg  <= sat16(57'(div_rsp.quotient), 1'b0);
                        state_reg <= S_PUSH;
                    end
                end
                S_GSTART: begin
                    if (idx_reg == '0) begin
                        e_reg     <= EXP_MAX;
                        state_reg <= S_GWRITE;
                    end else if (qsel == '0) begin
                        e_reg     <= '0;
                        state_reg <= S_GWRITE;
                    end else begin
                        div_req_reg.start    <= 1'b1;
                        div_req_reg.dividend <= DIV_W'(idx_reg) << 32;
                        div_req_reg.divisor  <= DEN_W'(qsel);
                        state_reg            <= S_GDIV;
                    end
                end
                S_GDIV: begin
                    if (div_rsp.done) begin
                        if (div_rsp.quotient >= R_LIMIT) begin
                            e_reg     <= '0;
                            state_reg <= S_GWRITE;
                        end else begin
                            exp_req_reg.start <= 1'b1;
                            exp_req_reg.r     <= div_rsp.quotient[R_W-1:0];
                            state_reg         <= S_GEXP;
                        end
                    end
                end
                S_GEXP: begin
                    if (exp_rsp.done) begin
                        e_reg     <= exp_rsp.e;
                        state_reg <= S_GWRITE;
                    end
                end
                S_GWRITE: begin
                    if (sel_reg) begin
                        ss_reg <= ss_reg + SUM_W'(e_reg);
                    end else begin
                        fs_reg <= fs_reg + SUM_W'(e_reg);
                    end
                    if (!sel_reg && cmd_reg != CMD_GAUSS) begin
                        sel_reg   <= 1'b1;
                        state_reg <= S_GSTART;
                    end else begin
                        sel_reg <= 1'b0;
                        if (is_last) begin
                            idx_reg   <= '0;
                            state_reg <= S_PREP;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_GSTART;
                        end
                    end
                end
                S_PREP: begin
                    dsum_reg  <= $signed({1'b0, fs_reg}) - $signed({1'b0, ss_reg});
                    state_reg <= S_RD;
                end
                S_RD: state_reg <= S_RDW;
                S_RDW: begin
                    t_reg <= rd_second;
                    unique case (cmd_reg)
                        CMD_GAUSS: begin
                            div_req_reg.start    <= 1'b1;
                            div_req_reg.dividend <= (DIV_W'(rd_first) << 15)
                                                    + DIV_W'(fs_reg >> 1);
                            div_req_reg.divisor  <= fs_reg;
                            neg_reg              <= 1'b0;
                            state_reg            <= S_DIVA;
                        end
                        CMD_SMOOTH: begin
                            if (dsum_reg == '0 || dval == '0) begin
                                coef_reg  <= '0;
                                state_reg <= S_PUSH;
                            end else begin
                                div_req_reg.start    <= 1'b1;
                                div_req_reg.dividend <= (DIV_W'(dmag) << 15)
                                                        + DIV_W'(smag >> 1);
                                div_req_reg.divisor  <= smag;
                                neg_reg              <= dval[24] ^ dsum_reg[32];
                                state_reg            <= S_DIVA;
                            end
                        end
                        CMD_DELTA: begin
                            div_req_reg.start    <= 1'b1;
                            div_req_reg.dividend <= (DIV_W'(rd_first) << 30)
                                                    + DIV_W'(fs_reg >> 1);
                            div_req_reg.divisor  <= fs_reg;
                            state_reg            <= S_DIVA;
                        end
                        CMD_RECT: begin
                            coef_reg  <= '0;
                            state_reg <= S_PUSH;
                        end
                        default: state_reg <= S_PUSH;
                    endcase
                end
                S_DIVA: begin
                    if (div_rsp.done) begin
                        if (cmd_reg == CMD_DELTA) begin
                            a_reg                <= div_rsp.quotient;
                            div_req_reg.start    <= 1'b1;
                            div_req_reg.dividend <= (DIV_W'(t_reg) << 30)
                                                    + DIV_W'(ss_reg >> 1);
                            div_req_reg.divisor  <= ss_reg;
                            state_reg            <= S_DIVB;
                        end else begin
                            coef_reg  <= sat16(57'(div_rsp.quotient), neg_reg);
                            state_reg <= S_PUSH;
                        end
                    end
                end
                S_DIVB: begin
                    if (div_rsp.done) begin
                        coef_reg  <= sat16((diff_mag + 57'h4000) >> 15, diff[56]);
                        state_reg <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (slot_free) begin
                        tap_valid_reg <= 1'b1;
                        tap_reg       <= '{coefficient: coef_reg,
                                           tap_index: idx_reg[5:0],
                                           last: is_last,
                                           truncated: trunc_reg,
                                           empty_res: 1'b0};
                        if (is_last) begin
                            state_reg <= S_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= (cmd_reg == CMD_RECT) ? S_PUSH : S_RD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign req_ready = state_reg == S_IDLE;
    assign tap_valid = tap_valid_reg;
    assign tap       = tap_reg;

endmodule

// ===== hdl/gwc_div.sv =====
// gwc_div: restoring divider, one quotient bit per cycle
// depends on gwc_pkg
module gwc_div (
    input  logic              clk,
    input  logic              rst_n,
    input  gwc_pkg::div_req_t req,
    output gwc_pkg::div_rsp_t rsp
);
    import gwc_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (req.start) begin
            rem_reg <= '0;
            den_reg <= req.divisor;
            quo_reg <= req.dividend;
        end else if (busy_reg) begin
            rem_reg <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== hdl/gwc_exp.sv =====
// gwc_exp: Q0.24 Gaussian from the scaled distance, shared multiplier sequencer
// depends on gwc_pkg
module gwc_exp (
    input  logic              clk,
    input  logic              rst_n,
    input  gwc_pkg::exp_req_t req,
    output gwc_pkg::exp_rsp_t rsp
);
    import gwc_pkg::*;

    typedef enum logic [3:0] {
        E_IDLE, E_MU, E_U, E_M2, E_W2, E_M3, E_W3, E_M4, E_W4,
        E_M5, E_W5, E_M6, E_W6, E_MS, E_SQ
    } est_t;

    localparam logic [31:0] RECIP3 = 32'hAAAAAAAB;
    localparam logic [21:0] U_LIMIT = 22'(17) << 16;

    est_t           state_reg;
    logic           done_reg;
    logic [E_W-1:0] e_reg;
    logic [31:0]    a_reg;
    logic [31:0]    b_reg;
    logic [63:0]    prod_reg;
    logic [26:0]    w_reg;
    logic [23:0]    w2_reg;
    logic [19:0]    w3_reg;
    logic [19:0]    t6_reg;
    logic [3:0]     k_reg;
    logic [21:0]    u;
    logic [31:0]    p_poly;
    logic [30:0]    p_sq;
    logic [25:0]    e_full;

    assign u      = prod_reg[37:16];
    assign p_poly = 32'h4000_0000 - 32'(w_reg) + 32'(w2_reg >> 1) - 32'(t6_reg)
                    + 32'(prod_reg[63:33]);
    assign p_sq   = 31'((prod_reg + 64'h2000_0000) >> 30);
    assign e_full = 26'((32'(p_sq) + 32'd32) >> 6);

    always_ff @(posedge clk) begin
        prod_reg <= a_reg * b_reg;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= E_IDLE;
            done_reg  <= 1'b0;
            e_reg     <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            w_reg     <= '0;
            w2_reg    <= '0;
            w3_reg    <= '0;
            t6_reg    <= '0;
            k_reg     <= '0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                E_IDLE: begin
                    if (req.start) begin
                        a_reg     <= 32'(req.r);
                        b_reg     <= 32'(req.r);
                        state_reg <= E_MU;
                    end
                end
                E_MU: state_reg <= E_U;
                E_U: begin
                    if (u >= U_LIMIT) begin
                        e_reg     <= '0;
                        done_reg  <= 1'b1;
                        state_reg <= E_IDLE;
                    end else begin
                        w_reg     <= {u[20:0], 6'b0};
                        a_reg     <= 32'({u[20:0], 6'b0});
                        b_reg     <= 32'({u[20:0], 6'b0});
                        state_reg <= E_M2;
                    end
                end
                E_M2: state_reg <= E_W2;
                E_W2: begin
                    w2_reg    <= 24'(prod_reg >> 30);
                    a_reg     <= 32'(prod_reg >> 30);
                    b_reg     <= 32'(w_reg);
                    state_reg <= E_M3;
                end
                E_M3: state_reg <= E_W3;
                E_W3: begin
                    w3_reg    <= 20'(prod_reg >> 30);
                    a_reg     <= 32'(prod_reg >> 30);
                    state_reg <= E_M4;
                end
                E_M4: state_reg <= E_W4;
                E_W4: begin
                    a_reg     <= 32'(w3_reg >> 1);
                    b_reg     <= RECIP3;
                    w3_reg    <= 20'(prod_reg >> 33);
                    state_reg <= E_M5;
                end
                E_M5: state_reg <= E_W5;
                E_W5: begin
                    t6_reg    <= 20'(prod_reg >> 33);
                    a_reg     <= 32'(w3_reg);
                    state_reg <= E_M6;
                end
                E_M6: state_reg <= E_W6;
                E_W6: begin
                    a_reg     <= p_poly;
                    b_reg     <= p_poly;
                    k_reg     <= '0;
                    state_reg <= E_MS;
                end
                E_MS: state_reg <= E_SQ;
                E_SQ: begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == 4'd7) begin
                        e_reg     <= (e_full > 26'(EXP_MAX)) ? EXP_MAX : e_full[23:0];
                        done_reg  <= 1'b1;
                        state_reg <= E_IDLE;
                    end else begin
                        a_reg     <= 32'(p_sq);
                        b_reg     <= 32'(p_sq);
                        state_reg <= E_MS;
                    end
                end
                default: state_reg <= E_IDLE;
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.e    = e_reg;

endmodule

// ===== hdl/gwc_store.sv =====
// gwc_store: the two Gaussian tap memories, one write port, registered read
// depends on gwc_pkg
module gwc_store #(
    parameter int MAX_TAPS = 64
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic                          sel,
    input  logic [$clog2(MAX_TAPS)-1:0]   wr_addr,
    input  logic [gwc_pkg::E_W-1:0]       wr_data,
    input  logic [$clog2(MAX_TAPS)-1:0]   rd_addr,
    output logic [gwc_pkg::E_W-1:0]       rd_first,
    output logic [gwc_pkg::E_W-1:0]       rd_second
);
    import gwc_pkg::*;

    logic [E_W-1:0] first_mem  [MAX_TAPS];
    logic [E_W-1:0] second_mem [MAX_TAPS];

    always_ff @(posedge clk) begin
        if (we && !sel) begin
            first_mem[wr_addr] <= wr_data;
        end
        rd_first <= first_mem[rd_addr];
    end

    always_ff @(posedge clk) begin
        if (we && sel) begin
            second_mem[wr_addr] <= wr_data;
        end
        rd_second <= second_mem[rd_addr];
    end

endmodule

// ===== hdl/gwc_checker.sv =====
// gwc_checker: port-level assertions for the window coefficient generator
// depends on gwc_pkg; bound to gaussian_window_coefficient_generator_unit
module gwc_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input gwc_pkg::req_t req,
    input logic          tap_valid,
    input logic          tap_ready,
    input gwc_pkg::tap_t tap
);
    import gwc_pkg::*;

    a_tap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tap_valid && !tap_ready |=> tap_valid && $stable(tap))
        else $error("tap transaction dropped or changed while stalled");

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while a window is in progress");

    a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
        tap_valid && tap.empty_res |->
            tap.last && !tap.truncated && tap.coefficient == 16'sd0 && tap.tap_index == 6'd0)
        else $error("malformed empty window marker");

    a_first_tap_idle: assert property (@(posedge clk) disable iff (!rst_n)
        tap_valid && tap_ready && !tap.last |-> !req_ready)
        else $error("ready for a request in the middle of a window");

endmodule

bind gaussian_window_coefficient_generator_unit gwc_checker u_gwc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .tap_valid (tap_valid),
    .tap_ready (tap_ready),
    .tap       (tap)
);

// ===== verif/tb_gaussian_window_coefficient_generator_unit.sv =====
// testbench for gaussian_window_coefficient_generator_unit: a directed and random request stream,
// each window's taps predicted in fixed point and compared in order
// depends on gwc_pkg and the unit rtl
module tb_gaussian_window_coefficient_generator_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import gwc_pkg::*;

    localparam int CAP_TAPS = 64;
    localparam int LIMIT_CYCLES = 20000000;
    localparam logic [63:0] K_TAPS = 64'd298338;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic tap_valid;
    logic tap_ready = 1'b0;
    tap_t tap;

    req_t pending_reqs[$];
    tap_t expected_taps[$];
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_cycles = 0;
    int errors = 0;
    int cycles = 0;

    gaussian_window_coefficient_generator_unit #(.MAX_TAPS(CAP_TAPS)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .tap_valid(tap_valid),
        .tap_ready(tap_ready),
        .tap(tap)
    );

    always #2 clk = ~clk;

    function automatic logic [23:0] gauss_q24(logic [63:0] i, logic [63:0] q);
        logic [63:0] r, u, w, w2, w3, w4, p, e;
        if (i == 0) return 24'hFFFFFF;
        if (q == 0) return 24'd0;
        r = (i << 32) / q;
        if (r >= (64'd5 << 16)) return 24'd0;
        u = (r * r) >> 16;
        if (u >= (64'd17 << 16)) return 24'd0;
        w = u << 6;
        w2 = (w * w) >> 30;
        w3 = (w2 * w) >> 30;
        w4 = (w3 * w) >> 30;
        p = (64'd1 << 30) - w + (w2 >> 1) - w3 / 6 + w4 / 24;
        for (int k = 0; k < 8; k++)
            p = (p * p + (64'd1 << 29)) >> 30;
        e = (p + 32) >> 6;
        if (e > 64'hFFFFFF) e = 64'hFFFFFF;
        return e[23:0];
    endfunction

    function automatic logic signed [15:0] clip_q15(logic [63:0] mag, logic neg);
        if (neg) return (mag > 32768) ? 16'sh8000 : 16'(64'd0 - mag);
        return (mag > 32767) ? 16'sh7FFF : mag[15:0];
    endfunction

    function automatic void predict_window(req_t r);
        logic [63:0] sc, q0, q1, qmax, n, fsum, ssum, h, t, a, b, md, ms;
        logic [23:0] g0[CAP_TAPS];
        logic [23:0] g1[CAP_TAPS];
        longint d, ds;
        logic trunc;
        tap_t x;
        sc = 64'(r.scale);
        q0 = sc << 8;
        q1 = sc * 64'(r.scale_mult);
        trunc = 1'b0;
        x = '0;
        if (cmd_t'(r.cmd) == CMD_RECT) begin
            n = sc >> 8;
            if (n == 0) begin
                x.last = 1'b1;
                x.empty_res = 1'b1;
                expected_taps.push_back(x);
                return;
            end
            if (n > CAP_TAPS) begin
                n = CAP_TAPS;
                trunc = 1'b1;
            end
            for (int i = 0; i < n; i++) begin
                x.coefficient = clip_q15(((64'd1 << 23) + sc / 2) / sc, 1'b0);
                x.tap_index = 6'(i);
                x.last = (i + 1 == n);
                x.truncated = trunc;
                expected_taps.push_back(x);
            end
            return;
        end
        qmax = (q1 > q0) ? q1 : q0;
        n = ((K_TAPS * qmax) >> 32) + 1;
        if (n > CAP_TAPS) begin
            n = CAP_TAPS;
            trunc = 1'b1;
        end
        fsum = 0;
        ssum = 0;
        for (int i = 0; i < n; i++) begin
            g0[i] = gauss_q24(64'(i), q0);
            g1[i] = (cmd_t'(r.cmd) == CMD_GAUSS) ? 24'd0 : gauss_q24(64'(i), q1);
            fsum = 64'(32'(fsum + g0[i]));
            ssum = 64'(32'(ssum + g1[i]));
        end
        for (int i = 0; i < n; i++) begin
            h = 64'(g0[i]);
            t = 64'(g1[i]);
            x.coefficient = '0;
            case (cmd_t'(r.cmd))
                CMD_GAUSS: x.coefficient = clip_q15(((h << 15) + fsum / 2) / fsum, 1'b0);
                CMD_SMOOTH: begin
                    ds = longint'(fsum) - longint'(ssum);
                    d = longint'(h) - longint'(t);
                    if (ds != 0 && d != 0) begin
                        md = (d < 0) ? 64'(-d) : 64'(d);
                        ms = (ds < 0) ? 64'(-ds) : 64'(ds);
                        x.coefficient = clip_q15(((md << 15) + ms / 2) / ms, (d < 0) != (ds < 0));
                    end
                end
                default: begin
                    a = ((h << 30) + fsum / 2) / fsum;
                    b = ((t << 30) + ssum / 2) / ssum;
                    d = longint'(a) - longint'(b);
                    md = (d < 0) ? 64'(-d) : 64'(d);
                    x.coefficient = clip_q15((md + (64'd1 << 14)) >> 15, d < 0);
                end
            endcase
            x.tap_index = 6'(i);
            x.last = (i + 1 == n);
            x.truncated = trunc;
            expected_taps.push_back(x);
        end
    endfunction

    function automatic req_t make_req(logic [1:0] c, logic [14:0] s, logic [11:0] m);
        req_t r;
        r.cmd = c;
        r.scale = s;
        r.scale_mult = m;
        return r;
    endfunction

    function automatic req_t random_req();
        logic [14:0] s;
        logic [11:0] m;
        if ($urandom_range(99) < 8) begin
            s = 15'($urandom);
            m = 12'($urandom);
        end else begin
            s = 15'($urandom_range(600));
            m = 12'($urandom_range(257, 700));
            if ($urandom_range(9) == 0) m = 12'($urandom_range(256));
        end
        return make_req(2'($urandom), s, m);
    endfunction

    // request driver
    always @(posedge clk) begin
        if (rst_n && (!req_valid || req_ready)) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
                req <= pending_reqs.pop_front();
                req_valid <= 1'b1;
            end else begin
                req_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && req_valid && req_ready)
            predict_window(req);
    end

    // tap receiver with optional long hold-off
    always @(posedge clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            tap_ready <= 1'b0;
        end else begin
            tap_ready <= rst_n && ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk) begin
        tap_t x;
        if (rst_n && tap_valid && tap_ready) begin
            if (expected_taps.size() == 0) begin
                $display("%0t: unexpected transaction, actual %p", $time, tap);
                errors++;
            end else begin
                x = expected_taps.pop_front();
                if (tap.coefficient !== x.coefficient || tap.tap_index !== x.tap_index ||
                    tap.last !== x.last || tap.truncated !== x.truncated ||
                    tap.empty_res !== x.empty_res) begin
                    $display("%0t: mismatch, expected %p, actual %p", $time, x, tap);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic drain();
        while (pending_reqs.size() > 0 || req_valid || expected_taps.size() > 0)
            @(posedge clk);
    endtask

    task automatic random_phase(int n, int ip, int sp);
        idle_pct = ip;
        stall_pct = sp;
        repeat (n) pending_reqs.push_back(random_req());
        drain();
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // extremes and special cases
        pending_reqs.push_back(make_req(CMD_RECT, 15'd0, 12'd512));
        pending_reqs.push_back(make_req(CMD_RECT, 15'd255, 12'd0));
        pending_reqs.push_back(make_req(CMD_RECT, 15'd256, 12'd512));
        pending_reqs.push_back(make_req(CMD_RECT, 15'd1000, 12'd4095));
        pending_reqs.push_back(make_req(CMD_RECT, 15'h7FFF, 12'd512));
        pending_reqs.push_back(make_req(CMD_GAUSS, 15'd0, 12'd512));
        pending_reqs.push_back(make_req(CMD_SMOOTH, 15'd0, 12'd4095));
        pending_reqs.push_back(make_req(CMD_DELTA, 15'd0, 12'd0));
        pending_reqs.push_back(make_req(CMD_GAUSS, 15'd1, 12'd257));
        pending_reqs.push_back(make_req(CMD_GAUSS, 15'd256, 12'd512));
        pending_reqs.push_back(make_req(CMD_SMOOTH, 15'd256, 12'd512));
        pending_reqs.push_back(make_req(CMD_DELTA, 15'd256, 12'd512));
        pending_reqs.push_back(make_req(CMD_SMOOTH, 15'd300, 12'd256));
        pending_reqs.push_back(make_req(CMD_SMOOTH, 15'd300, 12'd100));
        pending_reqs.push_back(make_req(CMD_DELTA, 15'd200, 12'd0));
        pending_reqs.push_back(make_req(CMD_GAUSS, 15'h7FFF, 12'd512));
        pending_reqs.push_back(make_req(CMD_SMOOTH, 15'd1500, 12'd4095));
        pending_reqs.push_back(make_req(CMD_DELTA, 15'd500, 12'd2048));
        pending_reqs.push_back(make_req(CMD_DELTA, 15'h2AAA, 12'hAAA));
        pending_reqs.push_back(make_req(CMD_GAUSS, 15'h5555, 12'h555));
        drain();

        random_phase(30, 0, 0);
        random_phase(30, 80, 0);
        hold_cycles = 3000;
        random_phase(30, 0, 80);
        random_phase(30, 10, 10);

        repeat (50) @(posedge clk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// ===== files.f =====
hdl/gwc_pkg.sv
hdl/gwc_div.sv
hdl/gwc_exp.sv
hdl/gwc_store.sv
hdl/gaussian_window_coefficient_generator_unit.sv
hdl/gwc_checker.sv
verif/tb_gaussian_window_coefficient_generator_unit.sv
